// ===== rtl/core/rmq_pkg.sv =====
// Package: widths, constants and payload types of the rotation matrix to quaternion block.
package rmq_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 18;
	localparam int W_W       = 17;
	localparam int SUM_W     = IN_W + 2;
	localparam int ARG_W     = IN_W + 1;
	localparam int DIFF_W    = IN_W + 1;
	localparam int RAD_W     = ARG_W + FRAC_BITS - 2;
	localparam int SQ_STEPS  = (RAD_W + 1) / 2;
	localparam int RADP_W    = 2 * SQ_STEPS;
	localparam int ROOT_W    = SQ_STEPS;
	localparam int REM_W     = ROOT_W + 2;
	localparam int W_MAX     = (1 << W_W) - 1;
	localparam int DEN_W     = W_W + 2;
	localparam int Q_W       = IN_W;
	localparam int NUM_W     = IN_W + FRAC_BITS;
	localparam int OVF_W     = W_W + IN_W + 2;
	localparam int DIV_STEPS = Q_W;
	localparam int LANES     = 3;
	localparam int V_MAX     = (1 << (IN_W - 1)) - 1;
	localparam int V_MIN_MAG = 1 << (IN_W - 1);

	typedef logic signed [IN_W-1:0]   entry_t;
	typedef logic [W_W-1:0]           wpart_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// one digit-by-digit square root stage
	typedef struct packed {
		logic [RADP_W-1:0] rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		diff_t             dx;
		diff_t             dy;
		diff_t             dz;
	} sq_t;

	// request from the root pipeline to the divider
	typedef struct packed {
		wpart_t w;
		diff_t  dx;
		diff_t  dy;
		diff_t  dz;
	} div_req_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   q;
		logic [Q_W-1:0]   nb;
	} lane_t;

	typedef struct packed {
		wpart_t                w;
		logic [DEN_W-1:0]      den;
		lane_t [LANES-1:0]     ln;
	} dv_t;

endpackage

// ===== rtl/core/rmq_in_if.sv =====
// Interface: matrix request channel.
interface rmq_in_if;
	import rmq_pkg::*;

	logic   valid;
	logic   ready;
	entry_t r00;
	entry_t r01;
	entry_t r02;
	entry_t r10;
	entry_t r11;
	entry_t r12;
	entry_t r20;
	entry_t r21;
	entry_t r22;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

// ===== rtl/core/rmq_out_if.sv =====
// Interface: quaternion result channel.
interface rmq_out_if;
	import rmq_pkg::*;

	logic   valid;
	logic   ready;
	wpart_t quat_w;
	entry_t quat_x;
	entry_t quat_y;
	entry_t quat_z;
	logic   degenerate;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, degenerate, output ready);
endinterface

// ===== rtl/core/rotation_matrix_to_quaternion_top.sv =====
// Top level: rotation matrix to unit quaternion, trace method, fully pipelined.
//
// Usage notes
//  - mat carries one request per 3x3 matrix, entries signed Q2.16.
//  - quat returns one result per request, in order: w unsigned Q1.16,
//    x/y/z signed Q2.16 saturated, degenerate when the scalar part is zero
//    (a negative trace argument clamps to zero and lands here too).
//  - Throughput: one request per cycle while quat takes results. The root
//    is found one bit per stage over 17 stages, each vector part by a
//    restoring divider one quotient bit per stage over 18 stages, the three
//    parts in parallel lanes. A request passes the input stage, 17 root
//    stages, divider set-up, 18 divide stages and the result register.
//  - Each stage has its own valid bit and loads when empty or when its
//    successor moves, so a stalled receiver fills the bubbles before mat
//    drops ready; nothing is lost or repeated.
//  - Reset clears the valid bits only; data registers are left as they are.
module rotation_matrix_to_quaternion_top (
	input  logic      clk,
	input  logic      arst_n,
	rmq_in_if.sink    mat,
	rmq_out_if.source quat
);
	import rmq_pkg::*;

	// input stage: trace argument and skew differences
	logic             v_s1;
	logic [ARG_W-1:0] arg_s1;
	diff_t            dx_s1, dy_s1, dz_s1;
	logic             rdy_s1;
	logic signed [SUM_W-1:0] sum;

	// root stages
	sq_t  sq_s2  [SQ_STEPS];
	logic v_s2   [SQ_STEPS];
	logic rdy_s2 [SQ_STEPS];
	sq_t  sq_in;

	// hand-over to the divider
	logic     div_rdy;
	div_req_t div_req;

	function automatic sq_t sq_step(sq_t a);
		sq_t              b;
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		b     = a;
		cur   = {a.rem, a.rad[RADP_W-1 -: 2]};
		trial = (REM_W+2)'({a.root, 2'b01});
		b.rad = a.rad << 2;
		if (cur >= trial) begin
			b.rem  = REM_W'(cur - trial);
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = REM_W'(cur);
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

	// 1 + trace, exact
	assign sum = SUM_W'(mat.r00) + SUM_W'(mat.r11) + SUM_W'(mat.r22)
		+ SUM_W'(1 << FRAC_BITS);

	// ready chain, back from the divider
	always_comb begin
		rdy_s2[SQ_STEPS-1] = !v_s2[SQ_STEPS-1] || div_rdy;
		for (int k = SQ_STEPS - 2; k >= 0; k--)
			rdy_s2[k] = !v_s2[k] || rdy_s2[k+1];
		rdy_s1 = !v_s1 || rdy_s2[0];
	end

	assign mat.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < SQ_STEPS; k++)
				v_s2[k] <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= mat.valid;
			if (rdy_s2[0])
				v_s2[0] <= v_s1;
			for (int k = 1; k < SQ_STEPS; k++)
				if (rdy_s2[k])
					v_s2[k] <= v_s2[k-1];
		end
	end

	// negative argument clamps to zero
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			arg_s1 <= sum[SUM_W-1] ? '0 : sum[ARG_W-1:0];
			dx_s1  <= DIFF_W'(mat.r21) - DIFF_W'(mat.r12);
			dy_s1  <= DIFF_W'(mat.r02) - DIFF_W'(mat.r20);
			dz_s1  <= DIFF_W'(mat.r10) - DIFF_W'(mat.r01);
		end
	end

	// radicand is arg scaled so the root comes out as sqrt(arg)/2 in Q1.16
	always_comb begin
		sq_in.rad  = RADP_W'({arg_s1, {(FRAC_BITS-2){1'b0}}});
		sq_in.rem  = '0;
		sq_in.root = '0;
		sq_in.dx   = dx_s1;
		sq_in.dy   = dy_s1;
		sq_in.dz   = dz_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2[0])
			sq_s2[0] <= sq_step(sq_in);
		for (int k = 1; k < SQ_STEPS; k++)
			if (rdy_s2[k])
				sq_s2[k] <= sq_step(sq_s2[k-1]);
	end

	always_comb begin
		div_req.w  = (sq_s2[SQ_STEPS-1].root > ROOT_W'(W_MAX)) ? wpart_t'(W_MAX)
			: W_W'(sq_s2[SQ_STEPS-1].root);
		div_req.dx = sq_s2[SQ_STEPS-1].dx;
		div_req.dy = sq_s2[SQ_STEPS-1].dy;
		div_req.dz = sq_s2[SQ_STEPS-1].dz;
	end

	rmq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2[SQ_STEPS-1]),
		.in_ready (div_rdy),
		.req      (div_req),
		.quat     (quat)
	);

	// degenerate result carries an all-zero quaternion
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.degenerate |->
		quat.quat_w == '0 && quat.quat_x == '0 && quat.quat_y == '0 && quat.quat_z == '0)
		else $error("degenerate result with non-zero parts");

	// a good result has a non-zero scalar part
	a_w_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.degenerate |-> quat.quat_w != '0)
		else $error("scalar part zero without degenerate flag");

	// a full input stage held by a stalled root pipe keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2[0] |=> v_s1 && $stable(arg_s1) && $stable(dx_s1))
		else $error("input stage lost a request under stall");

endmodule

// ===== rtl/core/rmq_divider.sv =====
// Three-lane restoring divider pipeline with saturation and the result register.
module rmq_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rmq_pkg::div_req_t req,
	rmq_out_if.source         quat
);
	import rmq_pkg::*;

	dv_t    dv_s3 [DIV_STEPS+1];
	logic   v_s3  [DIV_STEPS+1];
	logic   rdy_s3 [DIV_STEPS+1];
	logic   v_s4;
	logic   rdy_s4;
	wpart_t w_s4;
	entry_t qx_s4, qy_s4, qz_s4;
	logic   dg_s4;
	entry_t sat [LANES];

	function automatic lane_t lane_prep(diff_t d, wpart_t w);
		lane_t            l;
		logic [Q_W-1:0]   mag;
		logic [NUM_W-1:0] num;
		l.neg = d[DIFF_W-1];
		mag   = l.neg ? Q_W'(-d) : Q_W'(d);
		num   = {mag, {FRAC_BITS{1'b0}}};
		l.ovf = OVF_W'(num) >= OVF_W'({w, {(IN_W+2){1'b0}}});
		l.rem = DEN_W'(num[NUM_W-1:Q_W]);
		l.q   = '0;
		l.nb  = num[Q_W-1:0];
		return l;
	endfunction

	function automatic lane_t lane_step(lane_t a, logic [DEN_W-1:0] den);
		lane_t          b;
		logic [DEN_W:0] cur;
		b   = a;
		cur = {a.rem, a.nb[Q_W-1]};
		b.nb = a.nb << 1;
		if (cur >= {1'b0, den}) begin
			b.rem = DEN_W'(cur - {1'b0, den});
			b.q   = {a.q[Q_W-2:0], 1'b1};
		end else begin
			b.rem = DEN_W'(cur);
			b.q   = {a.q[Q_W-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic entry_t lane_sat(lane_t l);
		entry_t r;
		if (l.neg) begin
			if (l.ovf || l.q > Q_W'(V_MIN_MAG))
				r = entry_t'(IN_W'(V_MIN_MAG));
			else
				r = entry_t'(Q_W'(-l.q));
		end else begin
			if (l.ovf || l.q > Q_W'(V_MAX))
				r = entry_t'(IN_W'(V_MAX));
			else
				r = entry_t'(l.q);
		end
		return r;
	endfunction

	// ready ripples back from the result register
	always_comb begin
		rdy_s4 = !v_s4 || quat.ready;
		rdy_s3[DIV_STEPS] = !v_s3[DIV_STEPS] || rdy_s4;
		for (int k = DIV_STEPS - 1; k >= 0; k--)
			rdy_s3[k] = !v_s3[k] || rdy_s3[k+1];
	end

	assign in_ready = rdy_s3[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++)
				v_s3[k] <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3[0])
				v_s3[0] <= in_valid;
			for (int k = 1; k <= DIV_STEPS; k++)
				if (rdy_s3[k])
					v_s3[k] <= v_s3[k-1];
			if (rdy_s4)
				v_s4 <= v_s3[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3[0]) begin
			dv_s3[0].w     <= req.w;
			dv_s3[0].den   <= {req.w, 2'b00};
			dv_s3[0].ln[0] <= lane_prep(req.dx, req.w);
			dv_s3[0].ln[1] <= lane_prep(req.dy, req.w);
			dv_s3[0].ln[2] <= lane_prep(req.dz, req.w);
		end
		for (int k = 1; k <= DIV_STEPS; k++)
			if (rdy_s3[k]) begin
				dv_s3[k].w   <= dv_s3[k-1].w;
				dv_s3[k].den <= dv_s3[k-1].den;
				for (int j = 0; j < LANES; j++)
					dv_s3[k].ln[j] <= lane_step(dv_s3[k-1].ln[j], dv_s3[k-1].den);
			end
	end

	always_comb begin
		for (int j = 0; j < LANES; j++)
			sat[j] = lane_sat(dv_s3[DIV_STEPS].ln[j]);
	end

	// zero scalar part forces the vector to zero
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			w_s4  <= dv_s3[DIV_STEPS].w;
			dg_s4 <= (dv_s3[DIV_STEPS].w == '0);
			qx_s4 <= (dv_s3[DIV_STEPS].w == '0) ? '0 : sat[0];
			qy_s4 <= (dv_s3[DIV_STEPS].w == '0) ? '0 : sat[1];
			qz_s4 <= (dv_s3[DIV_STEPS].w == '0) ? '0 : sat[2];
		end
	end

	assign quat.valid      = v_s4;
	assign quat.quat_w     = w_s4;
	assign quat.quat_x     = qx_s4;
	assign quat.quat_y     = qy_s4;
	assign quat.quat_z     = qz_s4;
	assign quat.degenerate = dg_s4;

endmodule
